>>> rtl/core/pcs_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers of the PID controller step block.
// No dependencies.
package pcs_pkg;

  localparam int CFG_INDEX_W = 4;
  localparam int DIV_STEPS   = 64;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_P       = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_I       = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_D       = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_FF      = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTEGRAL_CAP = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEAD_ZONE    = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_RC    = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_VARY_BAND    = 4'd7;

  localparam logic [63:0] VARY_BAND_RESET = 64'd16777216;

  typedef struct packed {
    logic signed [31:0] target;
    logic signed [31:0] sensed;
    logic        [30:0] step_time;
    logic signed [31:0] ff_value;
  } in_item_t;

  typedef struct packed {
    logic signed [25:0] drive;
    logic               in_dead_zone;
  } out_item_t;

  typedef enum logic [1:0] {
    VR_KEEP,
    VR_SCALE,
    VR_ZERO
  } vr_mode_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DEAD,
    OP_MUL_P,
    OP_GET_P,
    OP_MUL_I,
    OP_GET_I,
    OP_ZERO_INC,
    OP_MUL_VR,
    OP_DIV_VR,
    OP_GET_VR,
    OP_INT_A,
    OP_INT_B,
    OP_ZERO_D,
    OP_MUL_D,
    OP_DIV_D,
    OP_GET_D,
    OP_MUL_F1,
    OP_MUL_F2,
    OP_DIV_F,
    OP_GET_F,
    OP_MUL_FF,
    OP_GET_FF,
    OP_FINISH
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_P,
    S_GET_P,
    S_MUL_I,
    S_GET_I,
    S_VR,
    S_DIV_VR,
    S_WAIT_VR,
    S_INT_A,
    S_INT_B,
    S_MUL_D,
    S_DIV_D,
    S_WAIT_D,
    S_FILT1,
    S_FILT2,
    S_DIV_F,
    S_WAIT_F,
    S_MUL_FF,
    S_GET_FF,
    S_FIN,
    S_DEAD
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic     deadband;
    vr_mode_t vr_mode;
    logic     dt_zero;
    logic     rc_zero;
    logic     div_done;
  } dp_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

>>> rtl/core/pcs_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider, 64-bit magnitude by 33-bit divisor.
// Signed result saturated to 32 bits. Uses pcs_pkg.
module pcs_div
  import pcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic        [63:0] dividend,
  input  logic        [32:0] divisor,
  input  logic               negate,
  output logic               done,
  output logic signed [31:0] quotient
);

  logic [32:0]          rem;
  logic [63:0]          quo;
  logic [32:0]          dvs;
  logic                 neg;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 active;
  logic [33:0]          trial;
  logic                 fits;
  logic [31:0]          neg_q;

  assign trial = {rem, quo[63]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
      neg <= negate;
    end else if (active) begin
      quo <= {quo[62:0], fits};
      rem <= fits ? 33'(trial - {1'b0, dvs}) : trial[32:0];
    end
  end

  assign neg_q = 32'(-quo[31:0]);

  always_comb begin
    if (neg) begin
      quotient = (quo > 64'h80000000) ? 32'sh80000000 : neg_q;
    end else begin
      quotient = (quo > 64'h7fffffff) ? 32'sh7fffffff : quo[31:0];
    end
  end

endmodule

>>> rtl/core/pcs_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the PID step: issues datapath commands, owns the handshakes.
// Uses pcs_pkg.
module pcs_ctrl
  import pcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic        slot_free;
  logic        fire;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= fire || (out_valid && !out_ready);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = S_CHECK;
      S_CHECK:   state_next = status.deadband ? S_DEAD : S_MUL_P;
      S_MUL_P:   state_next = S_GET_P;
      S_GET_P:   state_next = S_MUL_I;
      S_MUL_I:   state_next = S_GET_I;
      S_GET_I:   state_next = S_VR;
      S_VR:      state_next = (status.vr_mode == VR_SCALE) ? S_DIV_VR : S_INT_A;
      S_DIV_VR:  state_next = S_WAIT_VR;
      S_WAIT_VR: if (status.div_done) state_next = S_INT_A;
      S_INT_A:   state_next = S_INT_B;
      S_INT_B:   state_next = S_MUL_D;
      S_MUL_D: begin
        if (!status.dt_zero) begin
          state_next = S_DIV_D;
        end else begin
          state_next = status.rc_zero ? S_MUL_FF : S_FILT1;
        end
      end
      S_DIV_D:   state_next = S_WAIT_D;
      S_WAIT_D:  if (status.div_done) state_next = status.rc_zero ? S_MUL_FF : S_FILT1;
      S_FILT1:   state_next = S_FILT2;
      S_FILT2:   state_next = S_DIV_F;
      S_DIV_F:   state_next = S_WAIT_F;
      S_WAIT_F:  if (status.div_done) state_next = S_MUL_FF;
      S_MUL_FF:  state_next = S_GET_FF;
      S_GET_FF:  state_next = S_FIN;
      S_FIN:     if (slot_free) state_next = S_IDLE;
      S_DEAD:    if (slot_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    fire   = 1'b0;
    unique case (state)
      S_IDLE:    if (in_valid) cmd.op = OP_LOAD;
      S_CHECK:   cmd.op = OP_NONE;
      S_MUL_P:   cmd.op = OP_MUL_P;
      S_GET_P:   cmd.op = OP_GET_P;
      S_MUL_I:   cmd.op = OP_MUL_I;
      S_GET_I:   cmd.op = OP_GET_I;
      S_VR: begin
        unique case (status.vr_mode)
          VR_SCALE: cmd.op = OP_MUL_VR;
          VR_ZERO:  cmd.op = OP_ZERO_INC;
          default:  cmd.op = OP_NONE;
        endcase
      end
      S_DIV_VR:  cmd.op = OP_DIV_VR;
      S_WAIT_VR: if (status.div_done) cmd.op = OP_GET_VR;
      S_INT_A:   cmd.op = OP_INT_A;
      S_INT_B:   cmd.op = OP_INT_B;
      S_MUL_D:   cmd.op = status.dt_zero ? OP_ZERO_D : OP_MUL_D;
      S_DIV_D:   cmd.op = OP_DIV_D;
      S_WAIT_D:  if (status.div_done) cmd.op = OP_GET_D;
      S_FILT1:   cmd.op = OP_MUL_F1;
      S_FILT2:   cmd.op = OP_MUL_F2;
      S_DIV_F:   cmd.op = OP_DIV_F;
      S_WAIT_F:  if (status.div_done) cmd.op = OP_GET_F;
      S_MUL_FF:  cmd.op = OP_MUL_FF;
      S_GET_FF:  cmd.op = OP_GET_FF;
      S_FIN: begin
        if (slot_free) begin
          cmd.op = OP_FINISH;
          fire   = 1'b1;
        end
      end
      S_DEAD: begin
        if (slot_free) begin
          cmd.op = OP_DEAD;
          fire   = 1'b1;
        end
      end
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

>>> rtl/core/pcs_dp.sv
`timescale 1ns / 1ps
// Datapath of the PID step: registers, shared multiplier, shared divider.
// Uses pcs_pkg and pcs_div.
module pcs_dp
  import pcs_pkg::*;
#(
  parameter int FRAC_BITS            = 24,
  parameter int DERIV_ON_MEASUREMENT = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  in_item_t               in_item,
  output out_item_t              out_item,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data
);

  localparam logic signed [31:0] ONE_N = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [65:0] ONE_W = 66'sd1 <<< FRAC_BITS;

  logic signed [31:0] gain_p, gain_i, gain_d, gain_ff;
  logic        [30:0] integral_cap, dead_zone, filter_rc;
  logic        [63:0] vary_band;

  logic signed [31:0] sensed_c, err, ffv;
  logic        [30:0] dt;
  logic signed [31:0] integral_sum, prev_error, prev_sensed, prev_deriv;
  logic signed [31:0] p, inc, d, ff;
  logic signed [65:0] prod;
  logic signed [63:0] acc;
  logic               kill;

  logic signed [31:0] target_c, sensed_n;
  logic        [31:0] abs_err, vr_a, vr_b;
  logic        [32:0] vr_ab;
  logic        [31:0] vr_num;
  logic               same_sign;
  logic signed [32:0] err_sum;
  logic signed [31:0] half;
  logic signed [32:0] abs_inc;
  logic signed [31:0] diff;
  logic signed [32:0] mul_a, mul_b;
  logic               mul_en;
  logic        [63:0] div_dividend;
  logic        [32:0] div_divisor;
  logic               div_negate, div_start, div_done;
  logic signed [31:0] div_q;
  logic signed [65:0] prod_neg;
  logic signed [63:0] fsum, fsum_neg;
  logic signed [31:0] cand, int_next, cap_s;
  logic signed [65:0] trial, total;
  logic signed [31:0] inc_eff;

  function automatic logic signed [31:0] clamp_in(input logic signed [31:0] x);
    if (x > ONE_N) begin
      return ONE_N;
    end else if (x < -ONE_N) begin
      return -ONE_N;
    end else begin
      return x;
    end
  endfunction

  function automatic logic signed [31:0] qsat(input logic signed [65:0] x);
    return sat32(x >>> FRAC_BITS);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= '0;
      gain_i       <= '0;
      gain_d       <= '0;
      gain_ff      <= '0;
      integral_cap <= '0;
      dead_zone    <= '0;
      filter_rc    <= '0;
      vary_band    <= {32'h0, ONE_N};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GAIN_P:       gain_p       <= cfg_data[31:0];
        CFG_GAIN_I:       gain_i       <= cfg_data[31:0];
        CFG_GAIN_D:       gain_d       <= cfg_data[31:0];
        CFG_GAIN_FF:      gain_ff      <= cfg_data[31:0];
        CFG_INTEGRAL_CAP: integral_cap <= cfg_data[30:0];
        CFG_DEAD_ZONE:    dead_zone    <= cfg_data[30:0];
        CFG_FILTER_RC:    filter_rc    <= cfg_data[30:0];
        CFG_VARY_BAND:    vary_band    <= cfg_data;
        default:          ;
      endcase
    end
  end

  assign target_c = clamp_in(in_item.target);
  assign sensed_n = clamp_in(in_item.sensed);

  assign abs_err   = err[31] ? 32'(-err) : err;
  assign same_sign = (err > 32'sd0 && integral_sum > 32'sd0)
                  || (err < 32'sd0 && integral_sum < 32'sd0);
  assign vr_b      = vary_band[31:0];
  assign vr_a      = vary_band[63:32];
  assign vr_ab     = {1'b0, vr_a} + {1'b0, vr_b};
  assign vr_num    = 32'(vr_ab - {1'b0, abs_err});

  assign err_sum = 33'(err) + 33'(prev_error);
  assign half    = 32'(err_sum >>> 1);
  assign abs_inc = inc[31] ? -33'(inc) : 33'(inc);

  always_comb begin
    if (DERIV_ON_MEASUREMENT != 0) begin
      diff = sat32(66'(prev_sensed) - 66'(sensed_c));
    end else begin
      diff = sat32(66'(err) - 66'(prev_error));
    end
  end

  always_comb begin
    status.deadband = (dead_zone != '0) && (abs_err < {1'b0, dead_zone});
    status.vr_mode  = VR_KEEP;
    if (same_sign && abs_err > vr_b && vr_a != '0) begin
      status.vr_mode = ({1'b0, abs_err} <= vr_ab) ? VR_SCALE : VR_ZERO;
    end
    status.dt_zero  = (dt == '0);
    status.rc_zero  = (filter_rc == '0);
    status.div_done = div_done;
  end

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (cmd.op)
      OP_MUL_P: begin
        mul_a = 33'(gain_p);
        mul_b = 33'(err);
      end
      OP_MUL_I: begin
        mul_a = 33'(gain_i);
        mul_b = 33'(half);
      end
      OP_MUL_VR: begin
        mul_a = abs_inc;
        mul_b = {1'b0, vr_num};
      end
      OP_MUL_D: begin
        mul_a = 33'(gain_d);
        mul_b = 33'(diff);
      end
      OP_MUL_F1: begin
        mul_a = 33'(d);
        mul_b = {2'b00, dt};
      end
      OP_MUL_F2: begin
        mul_a = 33'(prev_deriv);
        mul_b = {2'b00, filter_rc};
      end
      OP_MUL_FF: begin
        mul_a = 33'(gain_ff);
        mul_b = 33'(ffv);
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign prod_neg = -prod;
  assign fsum     = acc + prod[63:0];
  assign fsum_neg = -fsum;

  always_comb begin
    div_start    = 1'b1;
    div_dividend = '0;
    div_divisor  = '0;
    div_negate   = 1'b0;
    unique case (cmd.op)
      OP_DIV_VR: begin
        div_dividend = prod[63:0];
        div_divisor  = {1'b0, vr_a};
        div_negate   = inc[31];
      end
      OP_DIV_D: begin
        div_dividend = prod[65] ? prod_neg[63:0] : prod[63:0];
        div_divisor  = {2'b00, dt};
        div_negate   = prod[65];
      end
      OP_DIV_F: begin
        div_dividend = fsum[63] ? fsum_neg : fsum;
        div_divisor  = {2'b00, filter_rc} + {2'b00, dt};
        div_negate   = fsum[63];
      end
      default: div_start = 1'b0;
    endcase
  end

  pcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .negate   (div_negate),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cand    = sat32(66'(integral_sum) + 66'(inc));
  assign trial   = 66'(p) + 66'(cand) + 66'(prev_deriv);
  assign inc_eff = kill ? 32'sd0 : inc;
  assign cap_s   = {1'b0, integral_cap};

  always_comb begin
    int_next = sat32(66'(integral_sum) + 66'(inc_eff));
    if (integral_cap != '0) begin
      if (int_next > cap_s) begin
        int_next = cap_s;
      end else if (int_next < -cap_s) begin
        int_next = -cap_s;
      end
    end
  end

  always_comb begin
    total = 66'(p) + 66'(integral_sum) + 66'(d) + 66'(ff);
    if (total > ONE_W) begin
      total = ONE_W;
    end else if (total < -ONE_W) begin
      total = -ONE_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      prev_error   <= '0;
      prev_sensed  <= '0;
      prev_deriv   <= '0;
    end else begin
      unique case (cmd.op)
        OP_DEAD: begin
          integral_sum <= '0;
          prev_error   <= err;
          prev_sensed  <= sensed_c;
        end
        OP_INT_B: integral_sum <= int_next;
        OP_FINISH: begin
          prev_error  <= err;
          prev_sensed <= sensed_c;
          prev_deriv  <= d;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    unique case (cmd.op)
      OP_LOAD: begin
        sensed_c <= sensed_n;
        err      <= target_c - sensed_n;
        dt       <= in_item.step_time;
        ffv      <= in_item.ff_value;
      end
      OP_DEAD: begin
        out_item.drive        <= '0;
        out_item.in_dead_zone <= 1'b1;
      end
      OP_GET_P:    p    <= qsat(prod);
      OP_GET_I:    inc  <= qsat(prod);
      OP_ZERO_INC: inc  <= '0;
      OP_GET_VR:   inc  <= div_q;
      OP_INT_A:    kill <= (integral_cap != '0) && same_sign
                         && (trial > ONE_W || trial < -ONE_W);
      OP_ZERO_D:   d    <= '0;
      OP_GET_D:    d    <= div_q;
      OP_MUL_F2:   acc  <= prod[63:0];
      OP_GET_F:    d    <= div_q;
      OP_GET_FF:   ff   <= qsat(prod);
      OP_FINISH: begin
        out_item.drive        <= total[25:0];
        out_item.in_dead_zone <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/pid_controller_step.sv
`timescale 1ns / 1ps
// PID controller step: top level joining sequencer and datapath.
// Uses pcs_pkg, pcs_ctrl, pcs_dp.
//
// Input channel in_valid/in_ready carries one item: setpoint, measurement,
// step time and feedforward value. Output channel out_valid/out_ready
// carries drive and the deadband flag, one result per item.
// Configuration writes use cfg_valid/cfg_ready with cfg_index/cfg_data;
// cfg_ready is always high and writes belong in idle periods.
// One item is worked at a time; in_ready is high only while idle.
// A deadband item goes from acceptance through a check to its result;
// any other item runs the full sequence, with up to three divisions
// (taper scaling, derivative over step time, derivative filter) on the
// shared 64-step radix-2 divider, and the filter products before the last.
// The result waits in an output register; the next item is accepted while
// it waits, and the block stalls at its final step only if the previous
// result is still untaken. Reset clears the controller state, registers
// and history; no result is pending after reset.
module pid_controller_step
  import pcs_pkg::*;
#(
  parameter int FRAC_BITS            = 24,
  parameter int DERIV_ON_MEASUREMENT = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  pcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pcs_dp #(
    .FRAC_BITS            (FRAC_BITS),
    .DERIV_ON_MEASUREMENT (DERIV_ON_MEASUREMENT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

>>> rtl/core/pcs_chk.sv
`timescale 1ns / 1ps
// Port-level checks of the PID controller step, bound to the top level.
// Uses pcs_pkg.
module pcs_chk
  import pcs_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_dead_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.in_dead_zone |-> out_item.drive == '0)
    else $error("deadband result with nonzero drive");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result pending after reset");

endmodule

bind pid_controller_step pcs_chk u_chk (.*);
